// File: rtl/bpc_pkg.sv
// Shared types, constants and helper functions for the barometric pressure compensation block.
// Depends on nothing; every other file of the block but bpc_stream_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Field and datapath widths.
    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int VALUE_W   = 32;
    localparam int WIDE_W    = 64;
    localparam int DT_W      = RAW_W + 1;
    localparam int TEMP_W    = 19;
    localparam int T2_W      = 18;
    localparam int SQ_W      = 2 * (TEMP_W - 1);
    localparam int MUL_B_W   = DT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS = 3'd5;

    // Item kinds.
    localparam logic ACTION_TEMP  = 1'b0;
    localparam logic ACTION_PRESS = 1'b1;

    // Temperature thresholds in hundredths of a degree.
    localparam logic signed [TEMP_W-1:0] TEMP_REF = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] TEMP_LOW = TEMP_W'(-1500);

    // Constant factors of the second-order offset correction.
    localparam logic [MUL_B_W-1:0] OFF2_FACTOR = MUL_B_W'(61);
    localparam logic [MUL_B_W-1:0] OFF3_FACTOR = MUL_B_W'(15);

    // Scaling shifts.
    localparam int REF_T_SHIFT   = 8;
    localparam int TEMP_SHIFT    = 23;
    localparam int T2_SHIFT      = 31;
    localparam int OFF_C_SHIFT   = 17;
    localparam int SENS_C_SHIFT  = 16;
    localparam int OFF_DT_SHIFT  = 6;
    localparam int SENS_DT_SHIFT = 7;
    localparam int OFF2_SHIFT    = 4;
    localparam int SENS2_SHIFT   = 1;
    localparam int SENS3_SHIFT   = 3;
    localparam int PRESS_SHIFT   = 21;
    localparam int OUT_SHIFT     = 15;

    localparam logic signed [WIDE_W-1:0] VALUE_MAX =
        {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] VALUE_MIN =
        {{(WIDE_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic              action;
        logic [RAW_W-1:0]  raw_reading;
    } in_item_t;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [COEF_W-1:0]    data;
    } cfg_item_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens_coefficient;
        logic [COEF_W-1:0] offset_coefficient;
        logic [COEF_W-1:0] sens_temp_coefficient;
        logic [COEF_W-1:0] offset_temp_coefficient;
        logic [COEF_W-1:0] reference_temperature;
        logic [COEF_W-1:0] temp_sensitivity;
    } coef_t;

    typedef struct packed {
        logic                      done;
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } core_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_MUL_T,
        ST_MUL_OFF,
        ST_MUL_SENS,
        ST_MUL_T2,
        ST_MUL_DD,
        ST_MUL_OFF2,
        ST_MUL_EE,
        ST_MUL_EE2,
        ST_FINISH_T,
        ST_MUL_P,
        ST_P_OFF,
        ST_P_OUT,
        ST_DONE
    } bpc_state_t;

    // Clamp a wide signed value to the 32-bit result range.
    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [WIDE_W-1:0] x);
        logic signed [VALUE_W-1:0] r;
        if (x > VALUE_MAX) begin
            r = VALUE_MAX[VALUE_W-1:0];
        end
        else if (x < VALUE_MIN) begin
            r = VALUE_MIN[VALUE_W-1:0];
        end
        else begin
            r = x[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Division by a power of two, rounding toward zero.
    function automatic logic signed [WIDE_W-1:0] trunc_shift(
        input logic signed [WIDE_W-1:0] x,
        input int unsigned              n
    );
        logic [WIDE_W-1:0]        bias;
        logic signed [WIDE_W-1:0] r;
        bias = (WIDE_W'(1) << n) - WIDE_W'(1);
        if (x[WIDE_W-1]) begin
            r = (x + $signed(bias)) >>> n;
        end
        else begin
            r = x >>> n;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bpc_stream_if.sv
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/bpc_serial_mult.sv
// Shift-add multiplier retiring one multiplier bit per cycle.
// Depends on bpc_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module bpc_serial_mult (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [bpc_pkg::WIDE_W-1:0]      a,
    input  logic [bpc_pkg::MUL_B_W-1:0]            b,
    output bpc_pkg::mul_status_t                   status,
    output logic signed [bpc_pkg::WIDE_W-1:0]      product
);
    import bpc_pkg::*;

    logic                       busy_reg, busy_next;
    logic signed [WIDE_W-1:0]   acc_reg, acc_next;
    logic signed [WIDE_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]         b_reg, b_next;

    // The product is complete once no multiplier bits remain.
    always_comb
    begin
        busy_next = busy_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
            end
            else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = a_reg <<< 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
        end
        else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (b_reg == '0);
    assign product     = acc_reg;

endmodule

`default_nettype wire

// File: rtl/bpc_cfg_regs.sv
// Calibration coefficient registers written through the configuration channel.
// Depends on bpc_pkg and bpc_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    bpc_stream_if.sink     cfg,
    output bpc_pkg::coef_t coef
);
    import bpc_pkg::*;

    coef_t coef_reg, coef_next;

    // Writes to indexes past the register list are dropped.
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg.valid) begin
            unique case (cfg.payload.index)
                REG_SENS:      coef_next.sens_coefficient        = cfg.payload.data;
                REG_OFFSET:    coef_next.offset_coefficient      = cfg.payload.data;
                REG_SENS_TC:   coef_next.sens_temp_coefficient   = cfg.payload.data;
                REG_OFFSET_TC: coef_next.offset_temp_coefficient = cfg.payload.data;
                REG_REF_TEMP:  coef_next.reference_temperature   = cfg.payload.data;
                REG_TEMP_SENS: coef_next.temp_sensitivity        = cfg.payload.data;
                default:       coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            coef_reg <= '0;
        end
        else begin
            coef_reg <= coef_next;
        end
    end

    assign cfg.ready = 1'b1;
    assign coef      = coef_reg;

endmodule

`default_nettype wire

// File: rtl/bpc_core.sv
// Compensation sequencer: steps through the arithmetic of one reading on the shared
// bit-serial multiplier. Depends on bpc_pkg and bpc_serial_mult.
`timescale 1ns / 1ps
`default_nettype none

module bpc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bpc_pkg::in_item_t  item,
    input  bpc_pkg::coef_t     coef,
    input  logic               take,
    output logic               idle,
    output bpc_pkg::core_res_t res
);
    import bpc_pkg::*;

    bpc_state_t                 state_reg, state_next;
    logic                       action_reg, action_next;
    logic [RAW_W-1:0]           raw_reg, raw_next;
    logic signed [DT_W-1:0]     dt_reg, dt_next;
    logic signed [TEMP_W-1:0]   temp_reg, temp_next;
    logic [T2_W-1:0]            t2_reg, t2_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic signed [WIDE_W-1:0]   off_reg, off_next;
    logic signed [WIDE_W-1:0]   sens_reg, sens_next;
    logic signed [WIDE_W-1:0]   wide_reg, wide_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;

    logic                       mul_start;
    logic signed [WIDE_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    mul_status_t                mul_st;
    logic signed [WIDE_W-1:0]   prod;
    logic                       in_mul;

    logic [DT_W-1:0]            dt_abs;
    logic signed [WIDE_W-1:0]   dt_wide;
    logic signed [TEMP_W-1:0]   d_val, e_val;
    logic [TEMP_W-1:0]          d_abs, e_abs;

    bpc_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_st),
        .product (prod)
    );

    // Magnitude of dt, distances from the two temperature thresholds and their magnitudes.
    always_comb
    begin
        dt_abs  = dt_reg[DT_W-1] ? DT_W'(-dt_reg) : DT_W'(dt_reg);
        dt_wide = WIDE_W'(dt_reg);
        d_val   = temp_reg - TEMP_REF;
        e_val   = temp_reg - TEMP_LOW;
        d_abs   = d_val[TEMP_W-1] ? TEMP_W'(-d_val) : TEMP_W'(d_val);
        e_abs   = e_val[TEMP_W-1] ? TEMP_W'(-e_val) : TEMP_W'(e_val);
    end

    // Multiplier operands for each step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_T:
            begin
                mul_a = dt_wide;
                mul_b = MUL_B_W'(coef.temp_sensitivity);
            end
            ST_MUL_OFF:
            begin
                mul_a = dt_wide;
                mul_b = MUL_B_W'(coef.offset_temp_coefficient);
            end
            ST_MUL_SENS:
            begin
                mul_a = dt_wide;
                mul_b = MUL_B_W'(coef.sens_temp_coefficient);
            end
            ST_MUL_T2:
            begin
                mul_a = $signed(WIDE_W'(dt_abs));
                mul_b = MUL_B_W'(dt_abs);
            end
            ST_MUL_DD:
            begin
                mul_a = $signed(WIDE_W'(d_abs));
                mul_b = MUL_B_W'(d_abs);
            end
            ST_MUL_OFF2:
            begin
                mul_a = $signed(WIDE_W'(sq_reg));
                mul_b = OFF2_FACTOR;
            end
            ST_MUL_EE:
            begin
                mul_a = $signed(WIDE_W'(e_abs));
                mul_b = MUL_B_W'(e_abs);
            end
            ST_MUL_EE2:
            begin
                mul_a = $signed(WIDE_W'(sq_reg));
                mul_b = OFF3_FACTOR;
            end
            ST_MUL_P:
            begin
                mul_a = sens_reg;
                mul_b = MUL_B_W'(raw_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = (item.action == ACTION_PRESS) ? ST_MUL_P : ST_DT;
                end
            end
            ST_DT:       state_next = ST_MUL_T;
            ST_MUL_T:    if (mul_st.done) state_next = ST_MUL_OFF;
            ST_MUL_OFF:  if (mul_st.done) state_next = ST_MUL_SENS;
            ST_MUL_SENS:
            begin
                if (mul_st.done) begin
                    state_next = (temp_reg < TEMP_REF) ? ST_MUL_T2 : ST_FINISH_T;
                end
            end
            ST_MUL_T2:   if (mul_st.done) state_next = ST_MUL_DD;
            ST_MUL_DD:   if (mul_st.done) state_next = ST_MUL_OFF2;
            ST_MUL_OFF2:
            begin
                if (mul_st.done) begin
                    state_next = e_val[TEMP_W-1] ? ST_MUL_EE : ST_FINISH_T;
                end
            end
            ST_MUL_EE:   if (mul_st.done) state_next = ST_MUL_EE2;
            ST_MUL_EE2:  if (mul_st.done) state_next = ST_FINISH_T;
            ST_FINISH_T: state_next = ST_DONE;
            ST_MUL_P:    if (mul_st.done) state_next = ST_P_OFF;
            ST_P_OFF:    state_next = ST_P_OUT;
            ST_P_OUT:    state_next = ST_DONE;
            ST_DONE:     if (take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_mul    = (state_reg == ST_MUL_T)    || (state_reg == ST_MUL_OFF)  ||
                    (state_reg == ST_MUL_SENS) || (state_reg == ST_MUL_T2)   ||
                    (state_reg == ST_MUL_DD)   || (state_reg == ST_MUL_OFF2) ||
                    (state_reg == ST_MUL_EE)   || (state_reg == ST_MUL_EE2)  ||
                    (state_reg == ST_MUL_P);
        mul_start = in_mul && !mul_st.busy;
        idle      = (state_reg == ST_IDLE);
        res.done  = (state_reg == ST_DONE);
        res.kind  = action_reg;
        res.value = value_reg;
    end

    // Datapath updates, each taken when its step completes.
    always_comb
    begin
        action_next = action_reg;
        raw_next    = raw_reg;
        dt_next     = dt_reg;
        temp_next   = temp_reg;
        t2_next     = t2_reg;
        sq_next     = sq_reg;
        off_next    = off_reg;
        sens_next   = sens_reg;
        wide_next   = wide_reg;
        value_next  = value_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    action_next = item.action;
                    raw_next    = item.raw_reading;
                end
            end
            ST_DT:
            begin
                dt_next = $signed({1'b0, raw_reg}) -
                          $signed({1'b0, coef.reference_temperature, {REF_T_SHIFT{1'b0}}});
            end
            ST_MUL_T:
            begin
                if (mul_st.done) begin
                    temp_next = TEMP_W'(prod >>> TEMP_SHIFT) + TEMP_REF;
                    t2_next   = '0;
                end
            end
            ST_MUL_OFF:
            begin
                if (mul_st.done) begin
                    off_next = ($signed(WIDE_W'(coef.offset_coefficient)) <<< OFF_C_SHIFT) +
                               (prod >>> OFF_DT_SHIFT);
                end
            end
            ST_MUL_SENS:
            begin
                if (mul_st.done) begin
                    sens_next = ($signed(WIDE_W'(coef.sens_coefficient)) <<< SENS_C_SHIFT) +
                                (prod >>> SENS_DT_SHIFT);
                end
            end
            ST_MUL_T2:
            begin
                if (mul_st.done) begin
                    t2_next = T2_W'(prod >> T2_SHIFT);
                end
            end
            ST_MUL_DD:
            begin
                if (mul_st.done) begin
                    sq_next = SQ_W'(prod);
                end
            end
            ST_MUL_OFF2:
            begin
                if (mul_st.done) begin
                    off_next  = off_reg - (prod >>> OFF2_SHIFT);
                    sens_next = sens_reg - ($signed(WIDE_W'(sq_reg)) <<< SENS2_SHIFT);
                end
            end
            ST_MUL_EE:
            begin
                if (mul_st.done) begin
                    sq_next = SQ_W'(prod);
                end
            end
            ST_MUL_EE2:
            begin
                if (mul_st.done) begin
                    off_next  = off_reg - prod;
                    sens_next = sens_reg - ($signed(WIDE_W'(sq_reg)) <<< SENS3_SHIFT);
                end
            end
            ST_FINISH_T:
            begin
                value_next = sat_value(WIDE_W'(temp_reg) - $signed(WIDE_W'(t2_reg)));
            end
            ST_MUL_P:
            begin
                if (mul_st.done) begin
                    wide_next = trunc_shift(prod, PRESS_SHIFT);
                end
            end
            ST_P_OFF:
            begin
                wide_next = wide_reg - off_reg;
            end
            ST_P_OUT:
            begin
                value_next = sat_value(trunc_shift(wide_reg, OUT_SHIFT));
            end
            ST_DONE:
            begin
                value_next = value_reg;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            off_reg   <= '0;
            sens_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            off_reg   <= off_next;
            sens_reg  <= sens_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        raw_reg    <= raw_next;
        dt_reg     <= dt_next;
        temp_reg   <= temp_next;
        t2_reg     <= t2_next;
        sq_reg     <= sq_next;
        wide_reg   <= wide_next;
        value_reg  <= value_next;
    end

endmodule

`default_nettype wire

// File: rtl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block: coefficient registers,
// compensation sequencer and output register. Depends on bpc_pkg, bpc_stream_if,
// bpc_cfg_regs and bpc_core.
//
//   Channel | Modport | Payload               | Transfer
//   --------+---------+-----------------------+---------------------------------
//   sample  | sink    | action, raw_reading   | one raw reading per transfer
//   result  | source  | kind, value           | one compensated value per reading
//   cfg     | sink    | index, data           | one coefficient write per transfer
//
// Multiplier: every product comes from one shift-add multiplier that retires a bit per cycle and
// stops when no set bits remain, so the time a reading takes follows its operands. A temperature
// reading takes longest with both low-temperature corrections and full-width operands; a pressure
// reading needs only one product.
// Reset: rst_n clears the coefficients, the stored offset and sensitivity, and all control.
// Stalls: a held result waits in the output register while the next reading is taken; a
// second result waits inside the sequencer until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation (
    input  logic         clk,
    input  logic         rst_n,
    bpc_stream_if.sink   sample,
    bpc_stream_if.source result,
    bpc_stream_if.sink   cfg
);
    import bpc_pkg::*;

    coef_t     coef;
    core_res_t core_res;
    logic      core_idle;
    logic      start;
    logic      take;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    // Calibration words written over the configuration channel.
    bpc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef)
    );

    // A reading is taken whenever the sequencer has nothing in hand.
    assign sample.ready = core_idle;
    assign start        = sample.valid && sample.ready;

    bpc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (sample.payload),
        .coef  (coef),
        .take  (take),
        .idle  (core_idle),
        .res   (core_res)
    );

    // The output register is refilled in the same cycle as its content leaves.
    assign take = core_res.done && (!out_valid_reg || result.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (take) begin
            out_valid_next      = 1'b1;
            out_item_next.kind  = core_res.kind;
            out_item_next.value = core_res.value;
        end
        else if (result.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // Only one reading is in the sequencer at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("reading accepted while another was still being compensated");

    // A finished result that cannot leave is held unchanged in the sequencer.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        core_res.done && !take |=> core_res.done && $stable(core_res.value))
        else $error("finished result lost while the output register was full");

    // The output register only fills from a completed sequencer result.
    a_out_from_core: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(take))
        else $error("result offered without a finished computation");

endmodule

`default_nettype wire
